### hdl/mrp_pkg.sv
// Shared types, constants and lookup functions of the meter report parser.
package mrp_pkg;

    // Bytes 0 to 12 are the only positions the decoder reads by index; the last byte is held apart.
    localparam int NUM_KEPT = 13;

    // Message length as seen by the decoder, saturated: any length of 15
    // or more can never match an expected length.
    localparam int LEN_W   = 4;
    localparam int LEN_MAX = 15;

    localparam logic [7:0] CMD_METER_REPORT = 8'h02;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_VERSION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_VERSION  = 1'd1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_REPORT = 3'd1;
    localparam logic [2:0] ST_BAD_VER    = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd4;
    localparam logic [2:0] ST_BAD_LEN    = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd6;
    localparam logic [2:0] ST_BAD_KWH    = 3'd7;

    localparam logic [8:0] MAX_INDEX = 9'd79;

    typedef struct packed {
        logic                      pend;
        logic                      ovf;
        logic [LEN_W-1:0]          len;
        logic [7:0]                last_byte;
        logic [NUM_KEPT-1:0][7:0]  bytes;
    } mrp_msg_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         meter_index;
        logic signed [31:0] reading;
        logic signed [31:0] prev_reading;
        logic [2:0]         decimals;
        logic [15:0]        delta_seconds;
        logic [1:0]         rate_kind;
        logic               exporting;
    } mrp_result_t;

    // Ten to the power of the precision.
    function automatic logic [23:0] pow10(input logic [2:0] prec);
        logic [23:0] r;
        begin
            unique case (prec)
                3'd0: r = 24'd1;
                3'd1: r = 24'd10;
                3'd2: r = 24'd100;
                3'd3: r = 24'd1000;
                3'd4: r = 24'd10000;
                3'd5: r = 24'd100000;
                3'd6: r = 24'd1000000;
                default: r = 24'd10000000;
            endcase
            return r;
        end
    endfunction

    // Lowest plausible raw kWh reading: minus one million units.
    function automatic logic signed [44:0] kwh_floor(input logic [2:0] prec);
        logic signed [44:0] r;
        begin
            unique case (prec)
                3'd0: r = -45'sd1000000;
                3'd1: r = -45'sd10000000;
                3'd2: r = -45'sd100000000;
                3'd3: r = -45'sd1000000000;
                3'd4: r = -45'sd10000000000;
                3'd5: r = -45'sd100000000000;
                3'd6: r = -45'sd1000000000000;
                default: r = -45'sd10000000000000;
            endcase
            return r;
        end
    endfunction

endpackage

### hdl/mrp_in_if.sv
// Byte channel into the meter report parser.
interface mrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       end_of_msg;

    modport source (output valid, output msg_byte, output end_of_msg, input ready);
    modport sink   (input valid, input msg_byte, input end_of_msg, output ready);
endinterface

### hdl/mrp_out_if.sv
// Decoded report channel out of the meter report parser.
interface mrp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [6:0]         meter_index;
    logic signed [31:0] reading;
    logic signed [31:0] prev_reading;
    logic [2:0]         decimals;
    logic [15:0]        delta_seconds;
    logic [1:0]         rate_kind;
    logic               exporting;

    modport source (
        output valid, output status, output meter_index, output reading,
        output prev_reading, output decimals, output delta_seconds,
        output rate_kind, output exporting, input ready
    );
    modport sink (
        input valid, input status, input meter_index, input reading,
        input prev_reading, input decimals, input delta_seconds,
        input rate_kind, input exporting, output ready
    );
endinterface

### hdl/mrp_buffer.sv
// Message byte collection: byte count, overflow flag and the closed-message snapshot.
module mrp_buffer
    import mrp_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] msg_byte,
    input  logic       end_of_msg,
    input  logic       taken,
    output mrp_msg_t   msg
);

    localparam int CW = $clog2(MAX_MSG_BYTES + 1);

    logic [CW-1:0]             count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic                      pend_reg, pend_next;
    logic [LEN_W-1:0]          fin_len_reg;
    logic                      fin_ovf_reg;
    logic [7:0]                last_reg;
    logic [NUM_KEPT-1:0][7:0]  bytes_reg;

    logic          room;
    logic [CW-1:0] new_cnt;
    logic          new_ovf;
    logic          closing;

    assign room    = count_reg < CW'(MAX_MSG_BYTES);
    assign new_cnt = room ? count_reg + CW'(1) : count_reg;
    assign new_ovf = ovf_reg | ~room;
    assign closing = accept & end_of_msg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            count_next = closing ? '0 : new_cnt;
            ovf_next   = closing ? 1'b0 : new_ovf;
        end
        if (closing)
        begin
            pend_next = 1'b1;
        end
        else
        begin
            pend_next = pend_reg & ~taken;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
        end
    end

    // Bytes past position 12 are counted but never stored in the byte array.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NUM_KEPT; i++)
            begin
                if (count_reg == CW'(i))
                begin
                    bytes_reg[i] <= msg_byte;
                end
            end
        end
        if (closing)
        begin
            fin_len_reg <= (new_cnt > CW'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                                    : new_cnt[LEN_W-1:0];
            fin_ovf_reg <= new_ovf;
            last_reg    <= msg_byte;
        end
    end

    assign msg.pend      = pend_reg;
    assign msg.ovf       = fin_ovf_reg;
    assign msg.len       = fin_len_reg;
    assign msg.last_byte = last_reg;
    assign msg.bytes     = bytes_reg;

endmodule

### hdl/mrp_decode.sv
// Field decode, length and index checks and the kWh plausibility test.
module mrp_decode
    import mrp_pkg::*;
(
    input  mrp_msg_t    msg,
    input  logic [7:0]  ver,
    input  logic [7:0]  highest,
    output mrp_result_t res
);

    logic [7:0]         d0, d1, d2;
    logic [NUM_KEPT-1:0][7:0] kept;
    logic [4:0]         mtype;
    logic [4:0]         type_m1;
    logic [4:0]         type_max;
    logic [1:0]         rate;
    logic [2:0]         size;
    logic               size_ok;
    logic [2:0]         scale1;
    logic               scale_ext;
    logic [7:0]         scale;
    logic [2:0]         prec;
    logic [7:0]         dhi, dlo;
    logic [15:0]        delta;
    logic               delta_nz;
    logic [4:0]         size5;
    logic [4:0]         expect_len;
    logic [4:0]         got_len;
    logic signed [31:0] cur, prev_raw, prev;
    logic [8:0]         idx;
    logic signed [44:0] c_ext, p_ext, lim;
    logic signed [33:0] diff;
    logic [32:0]        dmag;
    logic [39:0]        lhs, rhs;
    logic [23:0]        pw;
    logic               kwh_bad;
    logic [2:0]         st;
    logic               fill;

    // Positions past the end of the message read as zero, not as bytes left
    // over from an earlier message.
    always_comb
    begin
        for (int i = 0; i < NUM_KEPT; i++)
        begin
            kept[i] = (msg.len > LEN_W'(i)) ? msg.bytes[i] : 8'd0;
        end
    end

    assign d0 = msg.bytes[0];
    assign d1 = (msg.len > LEN_W'(1)) ? msg.bytes[1] : 8'd0;
    assign d2 = (msg.len > LEN_W'(2)) ? msg.bytes[2] : 8'd0;

    assign mtype     = d1[4:0];
    assign type_m1   = mtype - 5'd1;
    assign type_max  = (ver <= 8'd3) ? 5'd3 : 5'd5;
    assign rate      = (ver == 8'd1) ? 2'd0 : d1[6:5];
    assign size      = d2[2:0];
    assign size_ok   = (size == 3'd1) || (size == 3'd2) || (size == 3'd4);
    assign scale1    = {(ver >= 8'd3) & d1[7], d2[4:3]};
    assign scale_ext = (ver >= 8'd4) && (scale1 == 3'd7);
    assign scale     = scale_ext ? msg.last_byte + 8'd8 : {5'd0, scale1};
    assign prec      = d2[7:5];

    // Value and delta positions follow from the value size.
    always_comb
    begin
        unique case (size)
            3'd2:
            begin
                dhi      = kept[5];
                dlo      = kept[6];
                cur      = {{16{kept[3][7]}}, kept[3], kept[4]};
                prev_raw = {{16{kept[7][7]}}, kept[7], kept[8]};
            end
            3'd4:
            begin
                dhi      = kept[7];
                dlo      = kept[8];
                cur      = {kept[3], kept[4], kept[5], kept[6]};
                prev_raw = {kept[9], kept[10], kept[11], kept[12]};
            end
            default:
            begin
                dhi      = kept[4];
                dlo      = kept[5];
                cur      = {{24{kept[3][7]}}, kept[3]};
                prev_raw = {{24{kept[6][7]}}, kept[6]};
            end
        endcase
    end

    assign delta    = (ver == 8'd1) ? 16'd0 : {dhi, dlo};
    assign delta_nz = delta != 16'd0;
    assign prev     = delta_nz ? prev_raw : cur;
    assign size5    = {2'd0, size};

    assign expect_len = 5'd4 + size5
                      + ((ver >= 8'd2) ? 5'd2 + (delta_nz ? size5 : 5'd0) : 5'd0)
                      + (((ver >= 8'd5) && (scale1 == 3'd7)) ? 5'd1 : 5'd0);
    assign got_len    = {1'b0, msg.len} + 5'd1;

    assign idx = {type_m1, 4'd0} + {1'b0, scale};

    // Exact 64-bit style compares reduced to the widths the values need.
    assign pw    = pow10(prec);
    assign lim   = kwh_floor(prec);
    assign c_ext = 45'(cur);
    assign p_ext = 45'(prev);
    assign diff  = 34'(cur) - 34'(prev);
    assign dmag  = diff[33] ? 33'(-diff) : 33'(diff);
    assign lhs   = dmag * 7'd100;
    assign rhs   = delta * pw;

    assign kwh_bad = (c_ext < lim) || (p_ext < lim) || (lhs > rhs);

    always_comb
    begin
        priority if (msg.ovf)
            st = ST_BAD_LEN;
        else if (d0 != CMD_METER_REPORT)
            st = ST_NOT_REPORT;
        else if ((ver == 8'd0) || (ver > highest))
            st = ST_BAD_VER;
        else if ((mtype == 5'd0) || (mtype > type_max))
            st = ST_BAD_TYPE;
        else if (!size_ok)
            st = ST_BAD_SIZE;
        else if (expect_len != got_len)
            st = ST_BAD_LEN;
        else if (idx > MAX_INDEX)
            st = ST_BAD_INDEX;
        else if ((idx == 9'd0) && kwh_bad)
            st = ST_BAD_KWH;
        else
            st = ST_OK;
    end

    assign fill = (st == ST_OK) || (st == ST_BAD_KWH);

    assign res.status        = st;
    assign res.meter_index   = fill ? idx[6:0] : 7'd0;
    assign res.reading       = fill ? cur : 32'sd0;
    assign res.prev_reading  = fill ? prev : 32'sd0;
    assign res.decimals      = fill ? prec : 3'd0;
    assign res.delta_seconds = fill ? delta : 16'd0;
    assign res.rate_kind     = fill ? rate : 2'd0;
    assign res.exporting     = fill & (ver > 8'd1) & (rate == 2'd2);

endmodule

### hdl/meter_report_parser.sv
// Top level of the meter report parser: configuration, byte buffer, decode and result register.
//
//   channel      direction  payload
//   bytes        sink       msg_byte, end_of_msg
//   report       source     status, meter_index, reading, prev_reading, decimals,
//                           delta_seconds, rate_kind, exporting
//   cfg_*        write      cfg_index selects protocol_version or highest_version
//
// One byte is taken every cycle while input is not blocked. A closing byte marks its
// message pending in the byte buffer, and its report is loaded into the result
// register once that register is free; the whole decode is one combinational pass
// from the byte buffer. Reset clears the byte count and sets the versions to 1 and 6.
// A stalled report blocks input only while a second closed message waits to be decoded.
module meter_report_parser
    import mrp_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    mrp_in_if.sink               bytes,
    mrp_out_if.source            report
);

    logic [7:0]  ver_reg, ver_next;
    logic [7:0]  high_reg, high_next;
    logic        valid_reg, valid_next;
    mrp_result_t res_reg;

    mrp_msg_t    msg;
    mrp_result_t res;
    logic        res_free;
    logic        load;
    logic        accept;

    assign res_free     = ~valid_reg | report.ready;
    assign load         = msg.pend & res_free;
    assign bytes.ready  = ~msg.pend | res_free;
    assign accept       = bytes.valid & bytes.ready;

    mrp_buffer #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_buffer (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .msg_byte   (bytes.msg_byte),
        .end_of_msg (bytes.end_of_msg),
        .taken      (load),
        .msg        (msg)
    );

    mrp_decode u_decode (
        .msg     (msg),
        .ver     (ver_reg),
        .highest (high_reg),
        .res     (res)
    );

    always_comb
    begin
        ver_next  = ver_reg;
        high_next = high_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PROTOCOL_VERSION: ver_next  = cfg_data;
                REG_HIGHEST_VERSION:  high_next = cfg_data;
                default:              ver_next  = ver_reg;
            endcase
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg & ~report.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ver_reg   <= 8'd1;
            high_reg  <= 8'd6;
            valid_reg <= 1'b0;
        end
        else
        begin
            ver_reg   <= ver_next;
            high_reg  <= high_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign report.valid         = valid_reg;
    assign report.status        = res_reg.status;
    assign report.meter_index   = res_reg.meter_index;
    assign report.reading       = res_reg.reading;
    assign report.prev_reading  = res_reg.prev_reading;
    assign report.decimals      = res_reg.decimals;
    assign report.delta_seconds = res_reg.delta_seconds;
    assign report.rate_kind     = res_reg.rate_kind;
    assign report.exporting     = res_reg.exporting;

endmodule

### test/meter_report_parser_test.sv
// Self-checking testbench of the meter report parser: directed and random byte streams against a built-in decoder.
module meter_report_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mrp_pkg::*;

    localparam int MSG_BYTES = 16;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } msg_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PROTOCOL_VERSION;
    logic [7:0]           cfg_data = 8'h00;
    logic                 in_valid = 1'b0;
    logic [7:0]           in_byte = 8'h00;
    logic                 in_last = 1'b0;
    logic                 out_ready = 1'b0;

    mrp_in_if  byte_ch ();
    mrp_out_if report_ch ();

    assign byte_ch.valid      = in_valid;
    assign byte_ch.msg_byte   = in_byte;
    assign byte_ch.end_of_msg = in_last;
    assign report_ch.ready    = out_ready;

    meter_report_parser #(.MAX_MSG_BYTES(MSG_BYTES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (byte_ch),
        .report    (report_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder state as the block should hold it.
    logic [7:0]  held_bytes [MSG_BYTES];
    int unsigned held_count = 0;
    bit          held_overflow = 1'b0;
    logic [7:0]  cfg_version = 8'd1;
    logic [7:0]  cfg_top_version = 8'd6;

    mrp_result_t expected_reports [$];
    msg_byte_t   pending_bytes [$];
    logic [7:0]  frame [$];

    int unsigned queued_total = 0;
    int unsigned sent_count = 0;
    int unsigned accepted_count = 0;
    int unsigned reports_seen = 0;
    int unsigned error_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned in_calm = 0;
    int unsigned out_calm = 0;

    task automatic note_mismatch(input string msg);
    begin
        error_count++;
        if (error_count <= 100)
            $display("%0t: MISMATCH %s", $time, msg);
    end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    begin
        if (got !== want)
            note_mismatch($sformatf("report %0d: %s is %0h, expected %0h",
                                    reports_seen, name, got, want));
    end
    endtask

    function automatic logic [7:0] held_at(input int unsigned pos);
        if (pos < held_count && pos < MSG_BYTES)
            return held_bytes[pos];
        return 8'h00;
    endfunction

    // Big-endian value of 1, 2 or 4 bytes; the short sizes are sign extended.
    function automatic logic [31:0] field_value(input int unsigned pos, input int unsigned size);
        logic [31:0] v;
        logic [7:0]  head;
        v = '0;
        for (int i = 0; i < size; i++)
            v = (v << 8) + 32'(held_at(pos + i));
        head = held_at(pos);
        if (head[7])
        begin
            if (size == 1)
                v[31:8] = '1;
            else if (size == 2)
                v[31:16] = '1;
        end
        return v;
    endfunction

    function automatic mrp_result_t decode_report();
        mrp_result_t r;
        int unsigned ver, mtype, size, scale1, scale, need, idx;
        logic [7:0]  d1, d2;
        logic [2:0]  prec;
        logic [1:0]  rate;
        logic [15:0] delta;
        logic [31:0] cur, prev;
        longint      ten_pow, floor_val, c, p, diff;
        r = '0;
        ver = 32'(cfg_version);
        if (held_overflow)
        begin
            r.status = ST_BAD_LEN;
            return r;
        end
        if (held_at(0) != CMD_METER_REPORT)
        begin
            r.status = ST_NOT_REPORT;
            return r;
        end
        if (ver < 1 || ver > 32'(cfg_top_version))
        begin
            r.status = ST_BAD_VER;
            return r;
        end
        d1 = held_at(1);
        d2 = held_at(2);
        mtype = 32'(d1[4:0]);
        if (mtype < 1 || mtype > ((ver <= 3) ? 3 : 5))
        begin
            r.status = ST_BAD_TYPE;
            return r;
        end
        rate = (ver == 1) ? 2'd0 : d1[6:5];
        size = 32'(d2[2:0]);
        if (size != 1 && size != 2 && size != 4)
        begin
            r.status = ST_BAD_SIZE;
            return r;
        end
        scale1 = 32'(d2[4:3]);
        if (ver >= 3)
            scale1 = scale1 | (32'(d1[7]) << 2);
        scale = scale1;
        // The extended scale sits in the final byte of the message.
        if (ver >= 4 && scale1 == 7)
            scale = (32'(held_at(held_count - 1)) + 8) & 32'hff;
        prec = d2[7:5];
        delta = (ver == 1) ? 16'd0 : {held_at(3 + size), held_at(4 + size)};
        need = 4 + size;
        if (ver >= 2)
        begin
            need += 2;
            if (delta != 0)
                need += size;
        end
        if (ver >= 5 && scale1 == 7)
            need += 1;
        if (need != held_count + 1)
        begin
            r.status = ST_BAD_LEN;
            return r;
        end
        cur = field_value(3, size);
        prev = (delta != 0) ? field_value(5 + size, size) : cur;
        idx = (mtype - 1) * 16 + scale;
        if (idx > 79)
        begin
            r.status = ST_BAD_INDEX;
            return r;
        end
        r.status = ST_OK;
        r.meter_index = idx[6:0];
        r.reading = cur;
        r.prev_reading = prev;
        r.decimals = prec;
        r.delta_seconds = delta;
        r.rate_kind = rate;
        r.exporting = (ver > 1 && rate == 2'd2);
        // Electric kWh readings may not fall below minus one million units and
        // may not move faster than one hundredth of a unit per second.
        if (idx == 0)
        begin
            ten_pow = 1;
            for (int i = 0; i < prec; i++)
                ten_pow = ten_pow * 10;
            c = $signed(cur);
            p = $signed(prev);
            floor_val = -64'sd1000000 * ten_pow;
            diff = (c > p) ? c - p : p - c;
            if (c < floor_val || p < floor_val || diff * 100 > longint'(delta) * ten_pow)
                r.status = ST_BAD_KWH;
        end
        return r;
    endfunction

    function automatic void absorb_byte(input logic [7:0] value, input logic last);
        if (held_count < MSG_BYTES)
        begin
            held_bytes[held_count] = value;
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (last)
        begin
            expected_reports.push_back(decode_report());
            held_count = 0;
            held_overflow = 1'b0;
        end
    endfunction

    // Mostly no pause or a short one, a few long ones, and now and then a calm stretch with none.
    function automatic int unsigned draw_pause(inout int unsigned calm);
        int unsigned roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm = $urandom_range(30, 150);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A transaction completes on a rising edge with valid and ready both high.
    always @(posedge clk)
    begin
        mrp_result_t got, want;
        if (rst_n)
        begin
            if (report_ch.valid && report_ch.ready)
            begin
                got.status        = report_ch.status;
                got.meter_index   = report_ch.meter_index;
                got.reading       = report_ch.reading;
                got.prev_reading  = report_ch.prev_reading;
                got.decimals      = report_ch.decimals;
                got.delta_seconds = report_ch.delta_seconds;
                got.rate_kind     = report_ch.rate_kind;
                got.exporting     = report_ch.exporting;
                if (expected_reports.size() == 0)
                    note_mismatch($sformatf("report %0d arrived with no message outstanding",
                                            reports_seen));
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("meter_index", 32'(got.meter_index), 32'(want.meter_index));
                    check_field("reading", got.reading, want.reading);
                    check_field("prev_reading", got.prev_reading, want.prev_reading);
                    check_field("decimals", 32'(got.decimals), 32'(want.decimals));
                    check_field("delta_seconds", 32'(got.delta_seconds),
                                32'(want.delta_seconds));
                    check_field("rate_kind", 32'(got.rate_kind), 32'(want.rate_kind));
                    check_field("exporting", 32'(got.exporting), 32'(want.exporting));
                end
                reports_seen++;
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                absorb_byte(byte_ch.msg_byte, byte_ch.end_of_msg);
                accepted_count++;
            end
        end
    end

    always @(negedge clk)
    begin
        msg_byte_t next_item;
        if (rst_n && !(in_valid && accepted_count != sent_count))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_bytes.size() > 0)
            begin
                next_item = pending_bytes.pop_front();
                in_byte  <= next_item.value;
                in_last  <= next_item.last;
                in_valid <= 1'b1;
                sent_count++;
                gap_left = draw_pause(in_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = draw_pause(out_calm);
            end
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic last);
    begin
        pending_bytes.push_back('{value, last});
        queued_total++;
    end
    endtask

    task automatic send_frame();
    begin
        foreach (frame[i])
            push_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    end
    endtask

    task automatic put_value(input logic [31:0] v, input int unsigned size);
    begin
        for (int i = size - 1; i >= 0; i--)
            frame.push_back(v[8 * i +: 8]);
    end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    begin
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_PROTOCOL_VERSION)
            cfg_version = value;
        else
            cfg_top_version = value;
        @(negedge clk);
        cfg_write <= 1'b0;
    end
    endtask

    task automatic wait_idle();
    begin
        while (accepted_count != queued_total || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    end
    endtask

    // One meter report laid out for the given version, sometimes malformed.
    task automatic make_report(input int unsigned ver);
        logic [4:0]  mtype;
        logic [2:0]  scale1, size, prec;
        logic [1:0]  rate;
        logic [7:0]  d1, d2;
        logic [15:0] delta;
        logic [31:0] cur, prev;
        int unsigned nbytes;
        int          diff;
        longint      ten_pow;
        bit          kwh;
    begin
        kwh = ($urandom_range(0, 2) == 0);
        rate = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            mtype = 5'($urandom_range(0, 31));
        else
            mtype = 5'($urandom_range(1, (ver <= 3) ? 3 : 5));
        scale1 = 3'($urandom_range(0, 7));
        if (kwh)
        begin
            mtype = 5'd1;
            scale1 = (ver < 3) ? {1'($urandom_range(0, 1)), 2'b00} : 3'd0;
        end
        case ($urandom_range(0, 19))
            0, 1, 2:        size = 3'($urandom_range(0, 7));
            3, 4, 5, 6, 7:  size = 3'd1;
            8, 9, 10, 11:   size = 3'd2;
            default:        size = 3'd4;
        endcase
        nbytes = (size == 1 || size == 2 || size == 4) ? 32'(size) : $urandom_range(1, 4);
        prec = 3'($urandom_range(0, 7));
        cur = $urandom;
        prev = $urandom;
        case ($urandom_range(0, 3))
            0:       delta = 16'd0;
            1:       delta = 16'($urandom_range(1, 300));
            default: delta = 16'($urandom);
        endcase
        if (kwh)
        begin
            ten_pow = 1;
            for (int i = 0; i < prec; i++)
                ten_pow = ten_pow * 10;
            // Sit on or just either side of the lowest plausible reading.
            if (size == 4 && prec <= 3 && $urandom_range(0, 2) == 0)
                cur = 32'(-64'sd1000000 * ten_pow + longint'($urandom_range(0, 2)) - 1);
            diff = int'($urandom_range(0, 10)) - 5;
            prev = cur + 32'(diff);
            if (prec == 0 && diff != 0 && $urandom_range(0, 1) == 0)
                delta = 16'(((diff < 0) ? -diff : diff) * 100 + int'($urandom_range(0, 2)) - 1);
        end
        d1 = {scale1[2], rate, mtype};
        d2 = {prec, scale1[1:0], size};
        frame.push_back(CMD_METER_REPORT);
        frame.push_back(d1);
        frame.push_back(d2);
        put_value(cur, nbytes);
        if (ver >= 2)
        begin
            frame.push_back(delta[15:8]);
            frame.push_back(delta[7:0]);
            if (delta != 0)
                put_value(prev, nbytes);
        end
        if (ver >= 5 && scale1 == 7)
        begin
            case ($urandom_range(0, 2))
                0:       frame.push_back(8'($urandom_range(0, 15)));
                1:       frame.push_back(8'($urandom_range(248, 255)));
                default: frame.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0 && frame.size() > 1)
                void'(frame.pop_back());
            else
                frame.push_back(8'($urandom_range(0, 255)));
        end
        send_frame();
    end
    endtask

    task automatic run_phase(input logic [7:0] ver, input logic [7:0] top,
                             input int unsigned budget);
        int unsigned stop_at, roll, n;
    begin
        write_reg(REG_PROTOCOL_VERSION, ver);
        write_reg(REG_HIGHEST_VERSION, top);
        stop_at = queued_total + budget;
        while (queued_total < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                make_report(32'(ver));
            else if (roll < 90)
            begin
                // Noise, with closing flags scattered through it.
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++)
                    push_byte((i == 0 && $urandom_range(0, 1) == 0) ?
                              CMD_METER_REPORT : 8'($urandom_range(0, 255)),
                              i == n - 1 || $urandom_range(0, 7) == 0);
            end
            else
            begin
                // Around the buffer size; the longer ones overflow it.
                n = $urandom_range(MSG_BYTES - 1, MSG_BYTES + 8);
                frame.push_back(CMD_METER_REPORT);
                for (int i = 1; i < n; i++)
                    frame.push_back(8'($urandom_range(0, 255)));
                send_frame();
            end
        end
        wait_idle();
    end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed messages under the reset versions.
        frame = '{8'h00};
        send_frame();
        frame = '{CMD_METER_REPORT, 8'h01, 8'h01, 8'h80};
        send_frame();
        frame = '{CMD_METER_REPORT, 8'h03, 8'hE4, 8'h80, 8'h00, 8'h00, 8'h00};
        send_frame();
        frame = '{CMD_METER_REPORT, 8'h01, 8'h03};
        send_frame();
        frame = '{CMD_METER_REPORT, 8'h00, 8'h01, 8'h00};
        send_frame();
        frame = '{CMD_METER_REPORT, 8'h01, 8'h01};
        send_frame();
        frame = '{8'hFF};
        send_frame();
        wait_idle();

        run_phase(8'd2, 8'd6, 118);
        run_phase(8'd3, 8'd6, 118);
        run_phase(8'd4, 8'd6, 118);
        run_phase(8'd5, 8'd6, 118);
        run_phase(8'd6, 8'd6, 118);
        run_phase(8'd255, 8'd255, 118);
        run_phase(8'd7, 8'd6, 118);
        run_phase(8'd1, 8'd1, 118);
        run_phase(8'd2, 8'd1, 118);
        run_phase(8'd5, 8'd255, 118);
        run_phase(8'd4, 8'd4, 118);
        run_phase(8'd1, 8'd255, 118);

        for (int k = 0; k < 2000 && expected_reports.size() != 0; k++)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (expected_reports.size() != 0)
            note_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
